// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int unsigned DELAY_W   = 16;
	localparam int unsigned IN_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned BIT_CNT_W = 4;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_HALF_DELAY    = 1'b0,
		REG_QUARTER_DELAY = 1'b1
	} reg_index_t;

	// Input item kinds carried on tuser.
	typedef enum logic [0:0] {
		KIND_TICK    = 1'b0,
		KIND_COMMAND = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Bus sequencer phases. S* start, T* stop, W* write data bits,
	// WA* write acknowledge clock, R* read data bits, RA* read acknowledge.
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_S1   = 5'd1,
		PH_S2   = 5'd2,
		PH_T1   = 5'd3,
		PH_T2   = 5'd4,
		PH_T3   = 5'd5,
		PH_W1   = 5'd6,
		PH_W2   = 5'd7,
		PH_W3   = 5'd8,
		PH_W4   = 5'd9,
		PH_WA1  = 5'd10,
		PH_WA2  = 5'd11,
		PH_WA3  = 5'd12,
		PH_WA4  = 5'd13,
		PH_WA5  = 5'd14,
		PH_R1   = 5'd15,
		PH_R2   = 5'd16,
		PH_R3   = 5'd17,
		PH_RA1  = 5'd18,
		PH_RA2  = 5'd19,
		PH_RA3  = 5'd20,
		PH_RA4  = 5'd21,
		PH_RA5  = 5'd22,
		PH_RA6  = 5'd23
	} phase_t;

endpackage

// ===== src/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps

// Open-drain I2C master that carries out start, stop, write-byte and read-byte
// commands, paced by tick transactions on the input stream.
//
// Input stream (s_*): tuser is the item kind (0 tick, 1 command). Command
// fields are ignored on ticks, and a command that arrives while a previous one
// is still running is dropped. sda_in and scl_in are the sampled bus levels.
// Output stream (m_*): exactly one result transaction per input transaction,
// in order, carrying the line drives and status after that item.
//
// The result is registered: the item's effect is computed combinationally from
// the sequencer registers and captured with them in the output register.
// Throughput is one transaction per cycle while the receiver takes results;
// the only loop is the phase sequencer's next-state logic.
// When the receiver stalls, s_tready drops as soon as a result is waiting
// and not taken, so nothing is lost and the sequencer does not advance.
//
// Reset (arst_n low) returns the sequencer to idle with both lines released,
// clears the status and loads half_delay = 5 and quarter_delay = 3 ticks.
// Delay registers should be written while the engine is idle; a zero delay
// acts as one tick.
module i2c_master_byte_engine
	import i2cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] command, [9:2] write_data, [10] send_ack, [11] sda_in,
	// [12] scl_in, [15:13] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
	// [11:4] read_byte, [12] ack_seen, [15:13] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [DELAY_W-1:0]    cfg_data
);

	logic [DELAY_W-1:0]   half_delay_q;
	logic [DELAY_W-1:0]   quarter_delay_q;

	phase_t               phase_q, n_phase;
	logic [BIT_CNT_W-1:0] bit_count_q, n_bit_count;
	logic [DELAY_W-1:0]   wait_count_q, n_wait_count;
	logic [7:0]           shift_byte_q, n_shift_byte;
	logic                 ack_choice_q, n_ack_choice;
	logic                 clock_drive_q, n_clock_drive;
	logic                 data_drive_q, n_data_drive;
	logic                 last_ack_q, n_last_ack;
	logic [7:0]           last_read_q, n_last_read;
	logic                 done;

	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_DATA_W-1:0] result;

	logic                 in_accept;
	item_kind_t           kind;
	cmd_t                 command;
	logic [7:0]           write_data;
	logic                 send_ack;
	logic                 sda_in;
	logic                 scl_in;

	logic [DELAY_W-1:0]   half_eff;
	logic [DELAY_W-1:0]   quarter_eff;
	logic                 go;
	logic                 enter_en;
	phase_t               enter_ph;
	phase_t               leave_ph;

	assign kind       = item_kind_t'(s_tuser);
	assign command    = cmd_t'(s_tdata[1:0]);
	assign write_data = s_tdata[9:2];
	assign send_ack   = s_tdata[10];
	assign sda_in     = s_tdata[11];
	assign scl_in     = s_tdata[12];

	// The output register frees up in the same cycle it is read.
	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// A zero delay behaves as a single tick.
	assign half_eff    = (half_delay_q == '0) ? DELAY_W'(1) : half_delay_q;
	assign quarter_eff = (quarter_delay_q == '0) ? DELAY_W'(1) : quarter_delay_q;

	// Next-state logic: leave the current phase, then apply the actions of
	// the phase that is entered.
	always_comb begin
		n_phase       = phase_q;
		n_bit_count   = bit_count_q;
		n_wait_count  = wait_count_q;
		n_shift_byte  = shift_byte_q;
		n_ack_choice  = ack_choice_q;
		n_clock_drive = clock_drive_q;
		n_data_drive  = data_drive_q;
		n_last_ack    = last_ack_q;
		n_last_read   = last_read_q;
		done          = 1'b0;
		go            = 1'b0;
		enter_en      = 1'b0;
		enter_ph      = PH_IDLE;
		leave_ph      = PH_IDLE;

		if (kind == KIND_COMMAND) begin
			if (phase_q == PH_IDLE) begin
				n_bit_count = '0;
				enter_en    = 1'b1;
				case (command)
					CMD_START: enter_ph = PH_S1;
					CMD_STOP:  enter_ph = PH_T1;
					CMD_WRITE: begin
						n_shift_byte = write_data;
						enter_ph     = PH_W1;
					end
					default: begin
						n_shift_byte = '0;
						n_ack_choice = send_ack;
						enter_ph     = PH_R1;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			// Clock stretching: after a released high phase wait for SCL.
			if (phase_q inside {PH_W4, PH_WA4, PH_R3, PH_RA4}) begin
				go = scl_in;
			end else if (wait_count_q > DELAY_W'(1)) begin
				n_wait_count = wait_count_q - DELAY_W'(1);
			end else begin
				go = 1'b1;
			end

			if (go) begin
				case (phase_q)
					PH_S1:  leave_ph = PH_S2;
					PH_T1:  leave_ph = PH_T2;
					PH_T2:  leave_ph = PH_T3;
					PH_W1:  leave_ph = PH_W2;
					PH_W2:  leave_ph = PH_W3;
					PH_W3:  leave_ph = PH_W4;
					PH_W4: begin
						n_shift_byte = {shift_byte_q[6:0], 1'b0};
						n_bit_count  = bit_count_q + BIT_CNT_W'(1);
						leave_ph     = (n_bit_count >= BIT_CNT_W'(8)) ? PH_WA1 : PH_W1;
					end
					PH_WA1: leave_ph = PH_WA2;
					PH_WA2: leave_ph = PH_WA3;
					PH_WA3: leave_ph = PH_WA4;
					PH_WA4: begin
						n_last_ack = !sda_in;
						leave_ph   = PH_WA5;
					end
					PH_R1:  leave_ph = PH_R2;
					PH_R2:  leave_ph = PH_R3;
					PH_R3: begin
						n_shift_byte = {shift_byte_q[6:0], sda_in};
						n_bit_count  = bit_count_q + BIT_CNT_W'(1);
						if (n_bit_count >= BIT_CNT_W'(8)) begin
							n_last_read = n_shift_byte;
							leave_ph    = PH_RA1;
						end else begin
							leave_ph = PH_R1;
						end
					end
					PH_RA1: leave_ph = PH_RA2;
					PH_RA2: leave_ph = PH_RA3;
					PH_RA3: leave_ph = PH_RA4;
					PH_RA4: leave_ph = PH_RA5;
					PH_RA5: leave_ph = PH_RA6;
					default: leave_ph = PH_IDLE;
				endcase

				if (leave_ph == PH_IDLE) begin
					n_phase      = PH_IDLE;
					n_wait_count = '0;
					done         = 1'b1;
				end else begin
					enter_en = 1'b1;
					enter_ph = leave_ph;
				end
			end
		end

		if (enter_en) begin
			n_phase      = enter_ph;
			n_wait_count = '0;
			case (enter_ph)
				PH_S1:  begin n_clock_drive = 1'b0; n_wait_count = half_eff; end
				PH_S2:  begin n_data_drive = 1'b1; n_wait_count = half_eff; end
				PH_T1:  begin n_data_drive = 1'b1; n_wait_count = half_eff; end
				PH_T2:  begin n_clock_drive = 1'b0; n_wait_count = quarter_eff; end
				PH_T3:  begin n_data_drive = 1'b0; n_wait_count = half_eff; end
				PH_W1:  begin n_clock_drive = 1'b1; n_wait_count = quarter_eff; end
				PH_W2:  begin n_data_drive = !n_shift_byte[7]; n_wait_count = half_eff; end
				PH_W3:  begin n_clock_drive = 1'b0; n_wait_count = half_eff; end
				PH_WA1: begin n_clock_drive = 1'b1; n_wait_count = quarter_eff; end
				PH_WA2: begin n_data_drive = 1'b0; n_wait_count = half_eff; end
				PH_WA3: begin n_clock_drive = 1'b0; n_wait_count = half_eff; end
				PH_WA5: begin n_clock_drive = 1'b1; n_wait_count = half_eff; end
				PH_R1: begin
					n_clock_drive = 1'b1;
					n_data_drive  = 1'b0;
					n_wait_count  = half_eff;
				end
				PH_R2:  begin n_clock_drive = 1'b0; n_wait_count = half_eff; end
				PH_RA1: begin n_clock_drive = 1'b1; n_wait_count = quarter_eff; end
				PH_RA2: begin n_data_drive = n_ack_choice; n_wait_count = half_eff; end
				PH_RA3: begin n_clock_drive = 1'b0; n_wait_count = half_eff; end
				PH_RA5: begin n_clock_drive = 1'b1; n_wait_count = half_eff; end
				PH_RA6: begin n_data_drive = 1'b0; n_wait_count = half_eff; end
				default: ;
			endcase
		end
	end

	// Result word, packed as listed on the m_tdata port.
	always_comb begin
		result        = '0;
		result[0]     = n_clock_drive;
		result[1]     = n_data_drive;
		result[2]     = (n_phase != PH_IDLE);
		result[3]     = done;
		result[11:4]  = n_last_read;
		result[12]    = n_last_ack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_delay_q    <= DELAY_W'(5);
			quarter_delay_q <= DELAY_W'(3);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_HALF_DELAY:    half_delay_q <= cfg_data;
				REG_QUARTER_DELAY: quarter_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			wait_count_q  <= '0;
			shift_byte_q  <= '0;
			ack_choice_q  <= 1'b0;
			clock_drive_q <= 1'b0;
			data_drive_q  <= 1'b0;
			last_ack_q    <= 1'b0;
			last_read_q   <= '0;
		end else if (in_accept) begin
			phase_q       <= n_phase;
			bit_count_q   <= n_bit_count;
			wait_count_q  <= n_wait_count;
			shift_byte_q  <= n_shift_byte;
			ack_choice_q  <= n_ack_choice;
			clock_drive_q <= n_clock_drive;
			data_drive_q  <= n_data_drive;
			last_ack_q    <= n_last_ack;
			last_read_q   <= n_last_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= result;
		end
	end

	// A command accepted while idle always starts a sequence.
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && kind == KIND_COMMAND && phase_q == PH_IDLE |=> phase_q != PH_IDLE)
		else $error("command accepted while idle did not start a sequence");

	// The bit counter never runs past the eighth bit.
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BIT_CNT_W'(8))
		else $error("bit counter out of range");

	// A stretched clock holds the sequencer in its wait phase.
	a_stretch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && kind == KIND_TICK && !scl_in &&
		(phase_q == PH_W4 || phase_q == PH_WA4 || phase_q == PH_R3 || phase_q == PH_RA4)
		|=> $stable(phase_q))
		else $error("sequencer left a stretch phase while SCL was low");

	// Without an accepted transaction the sequencer does not move.
	a_no_accept_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(phase_q) && $stable(wait_count_q) && $stable(bit_count_q))
		else $error("sequencer state changed without an accepted transaction");

	// A finished command is reported with the engine no longer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[3] |-> !out_data_q[2])
		else $error("done reported while still busy");

endmodule

// ===== tb/i2c_master_byte_engine_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port, keeps its own copy of the bus
// sequencer and compares every result transaction with the predicted status.
module i2c_master_byte_engine_checker
	import i2cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [DELAY_W-1:0]    cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output logic                  engine_busy
);

	typedef struct packed {
		logic       ack_seen;
		logic [7:0] read_byte;
		logic       done;
		logic       busy;
		logic       sda_low;
		logic       scl_low;
	} line_status_t;

	line_status_t pending_status[$];

	// Predicted sequencer state.
	logic [DELAY_W-1:0]   half_dly;
	logic [DELAY_W-1:0]   quarter_dly;
	phase_t               bus_phase;
	logic [BIT_CNT_W-1:0] bit_cnt;
	logic [DELAY_W-1:0]   wait_cnt;
	logic [7:0]           shreg;
	logic                 ack_sel;
	logic                 scl_drv;
	logic                 sda_drv;
	logic                 ack_last;
	logic [7:0]           rd_last;

	task automatic enter_phase(input phase_t p);
		logic [DELAY_W-1:0] h;
		logic [DELAY_W-1:0] q;
		h = (half_dly == '0) ? DELAY_W'(1) : half_dly;
		q = (quarter_dly == '0) ? DELAY_W'(1) : quarter_dly;
		bus_phase = p;
		wait_cnt = '0;
		case (p)
			PH_S1: begin scl_drv = 1'b0; wait_cnt = h; end
			PH_S2: begin sda_drv = 1'b1; wait_cnt = h; end
			PH_T1: begin sda_drv = 1'b1; wait_cnt = h; end
			PH_T2: begin scl_drv = 1'b0; wait_cnt = q; end
			PH_T3: begin sda_drv = 1'b0; wait_cnt = h; end
			PH_W1: begin scl_drv = 1'b1; wait_cnt = q; end
			PH_W2: begin sda_drv = ~shreg[7]; wait_cnt = h; end
			PH_W3: begin scl_drv = 1'b0; wait_cnt = h; end
			PH_WA1: begin scl_drv = 1'b1; wait_cnt = q; end
			PH_WA2: begin sda_drv = 1'b0; wait_cnt = h; end
			PH_WA3: begin scl_drv = 1'b0; wait_cnt = h; end
			PH_WA5: begin scl_drv = 1'b1; wait_cnt = h; end
			PH_R1: begin scl_drv = 1'b1; sda_drv = 1'b0; wait_cnt = h; end
			PH_R2: begin scl_drv = 1'b0; wait_cnt = h; end
			PH_RA1: begin scl_drv = 1'b1; wait_cnt = q; end
			PH_RA2: begin sda_drv = ack_sel; wait_cnt = h; end
			PH_RA3: begin scl_drv = 1'b0; wait_cnt = h; end
			PH_RA5: begin scl_drv = 1'b1; wait_cnt = h; end
			PH_RA6: begin sda_drv = 1'b0; wait_cnt = h; end
			default: ;
		endcase
	endtask

	// Finishes the current phase and picks the next one; idle means done.
	task automatic leave_phase(input logic sda, output phase_t nxt);
		nxt = PH_IDLE;
		case (bus_phase)
			PH_S1: nxt = PH_S2;
			PH_T1: nxt = PH_T2;
			PH_T2: nxt = PH_T3;
			PH_W1: nxt = PH_W2;
			PH_W2: nxt = PH_W3;
			PH_W3: nxt = PH_W4;
			PH_W4: begin
				shreg = {shreg[6:0], 1'b0};
				bit_cnt = bit_cnt + 1'b1;
				nxt = (bit_cnt >= 4'd8) ? PH_WA1 : PH_W1;
			end
			PH_WA1: nxt = PH_WA2;
			PH_WA2: nxt = PH_WA3;
			PH_WA3: nxt = PH_WA4;
			PH_WA4: begin
				ack_last = ~sda;
				nxt = PH_WA5;
			end
			PH_R1: nxt = PH_R2;
			PH_R2: nxt = PH_R3;
			PH_R3: begin
				shreg = {shreg[6:0], sda};
				bit_cnt = bit_cnt + 1'b1;
				if (bit_cnt >= 4'd8) begin
					rd_last = shreg;
					nxt = PH_RA1;
				end else begin
					nxt = PH_R1;
				end
			end
			PH_RA1: nxt = PH_RA2;
			PH_RA2: nxt = PH_RA3;
			PH_RA3: nxt = PH_RA4;
			PH_RA4: nxt = PH_RA5;
			PH_RA5: nxt = PH_RA6;
			default: nxt = PH_IDLE;
		endcase
	endtask

	task automatic advance_sequencer(input item_kind_t kind, input cmd_t cmd,
			input logic [7:0] wdata, input logic sack, input logic sda,
			input logic scl, output line_status_t res);
		logic   go;
		logic   done;
		phase_t nxt;
		done = 1'b0;
		go = 1'b0;
		if (kind == KIND_COMMAND) begin
			// Commands are dropped while a sequence is running.
			if (bus_phase == PH_IDLE) begin
				bit_cnt = '0;
				case (cmd)
					CMD_START: enter_phase(PH_S1);
					CMD_STOP: enter_phase(PH_T1);
					CMD_WRITE: begin
						shreg = wdata;
						enter_phase(PH_W1);
					end
					default: begin
						shreg = '0;
						ack_sel = sack;
						enter_phase(PH_R1);
					end
				endcase
			end
		end else if (bus_phase != PH_IDLE) begin
			if (bus_phase inside {PH_W4, PH_WA4, PH_R3, PH_RA4})
				go = scl;
			else if (wait_cnt > 1)
				wait_cnt = wait_cnt - 1'b1;
			else
				go = 1'b1;
			if (go) begin
				leave_phase(sda, nxt);
				if (nxt == PH_IDLE) begin
					bus_phase = PH_IDLE;
					wait_cnt = '0;
					done = 1'b1;
				end else begin
					enter_phase(nxt);
				end
			end
		end
		res.scl_low = scl_drv;
		res.sda_low = sda_drv;
		res.busy = (bus_phase != PH_IDLE);
		res.done = done;
		res.read_byte = rd_last;
		res.ack_seen = ack_last;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		line_status_t want;
		line_status_t res;
		if (!arst_n) begin
			half_dly = 16'd5;
			quarter_dly = 16'd3;
			bus_phase = PH_IDLE;
			bit_cnt = '0;
			wait_cnt = '0;
			shreg = '0;
			ack_sel = 1'b0;
			scl_drv = 1'b0;
			sda_drv = 1'b0;
			ack_last = 1'b0;
			rd_last = '0;
			fail_count = 0;
			pending_status.delete();
			outstanding <= 0;
			engine_busy <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_status.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %0h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = pending_status.pop_front();
					check_field("scl_pull_low", 8'(want.scl_low), 8'(m_tdata[0]));
					check_field("sda_pull_low", 8'(want.sda_low), 8'(m_tdata[1]));
					check_field("busy_res", 8'(want.busy), 8'(m_tdata[2]));
					check_field("done_res", 8'(want.done), 8'(m_tdata[3]));
					check_field("read_byte", want.read_byte, m_tdata[11:4]);
					check_field("ack_seen", 8'(want.ack_seen), 8'(m_tdata[12]));
					check_field("padding", 8'd0, 8'(m_tdata[15:13]));
				end
			end
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_HALF_DELAY: half_dly = cfg_data;
					default: quarter_dly = cfg_data;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_sequencer(item_kind_t'(s_tuser), cmd_t'(s_tdata[1:0]),
					s_tdata[9:2], s_tdata[10], s_tdata[11], s_tdata[12], res);
				pending_status.push_back(res);
			end
			outstanding <= pending_status.size();
			engine_busy <= (bus_phase != PH_IDLE);
		end
	end

endmodule

// ===== tb/tb_i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the I2C master byte engine. All prediction and
// comparison live in the checker instance; this module only drives the
// streams and the register port and decides pass or fail at the end.
module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [DELAY_W-1:0]    cfg_data;

	int   fail_count;
	int   outstanding;
	logic engine_busy;

	// Percent chance per cycle that the sender or the receiver sits idle.
	int src_idle_pct;
	int sink_idle_pct;
	// When set above zero, the receiver process holds m_tready low for a hold-off
	// whose length this sets, while the sender keeps offering transactions.
	int sink_hold;
	int items_sent;

	always #5 clk = ~clk;

	i2c_master_byte_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	i2c_master_byte_engine_checker status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.engine_busy(engine_busy)
	);

	// Offers one input transaction and returns at the edge where it is taken.
	// s_tvalid is only lowered inside an idle gap, so back-to-back items keep
	// it high without a second assignment in the same time step.
	task automatic send_item(input item_kind_t kind, input cmd_t cmd,
			input logic [7:0] wdata, input logic sack, input logic sda,
			input logic scl);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, scl, sda, sack, wdata, cmd};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// A time tick with a random data line. The command fields are filled with
	// noise, since the engine must ignore them on ticks. A held-low clock line
	// makes the engine wait in its clock stretching phases.
	task automatic send_tick(input int stretch_pct);
		send_item(KIND_TICK, cmd_t'($urandom_range(3)), 8'($urandom),
			1'($urandom), 1'($urandom), $urandom_range(99) >= stretch_pct);
	endtask

	// Ticks the engine until it reports idle. engine_busy is registered and
	// trails the last accepted item, so the loop ends with one spare tick on an idle
	// engine, which is harmless. Noise sends a random command mid-sequence,
	// which the engine has to drop.
	task automatic tick_until_idle(input int stretch_pct, input int noise_pct);
		do begin
			if ($urandom_range(99) < noise_pct)
				send_item(KIND_COMMAND, cmd_t'($urandom_range(3)), 8'($urandom),
					1'($urandom), 1'($urandom), 1'($urandom));
			else
				send_tick(stretch_pct);
		end while (engine_busy);
	endtask

	// Holds the sender off until every result has been delivered. The count
	// that the loop reads already includes the last accepted item.
	task automatic wait_results();
		do begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	// Brings the engine to idle and drains the output side.
	task automatic settle();
		tick_until_idle(0, 0);
		wait_results();
	endtask

	// Writes both delay registers on consecutive edges; the enable stays high
	// across the pair.
	task automatic write_delays(input logic [DELAY_W-1:0] half,
			input logic [DELAY_W-1:0] quarter);
		cfg_we <= 1'b1;
		cfg_index <= REG_HALF_DELAY;
		cfg_data <= half;
		@(posedge clk);
		cfg_index <= REG_QUARTER_DELAY;
		cfg_data <= quarter;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic issue(input cmd_t cmd, input logic [7:0] wdata,
			input logic sack);
		send_item(KIND_COMMAND, cmd, wdata, sack, 1'($urandom), 1'($urandom));
	endtask

	// Random bus traffic: mostly complete commands with random content, each
	// ticked through to the end, with some stretching, dropped commands and
	// idle ticks in between. Halfway through it optionally starts a long
	// receiver hold-off or pauses the sender until all results are in.
	task automatic random_phase(input int target, input bit with_holdoff,
			input bit with_pause);
		int first;
		int stretch;
		bit pressed;
		first = items_sent;
		pressed = 1'b0;
		while (items_sent - first < target) begin
			if (!pressed && items_sent - first > target / 2) begin
				pressed = 1'b1;
				if (with_holdoff)
					sink_hold = 400;
				if (with_pause)
					wait_results();
			end
			case ($urandom_range(2))
				0: stretch = 0;
				1: stretch = 10;
				default: stretch = 40;
			endcase
			issue(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
			tick_until_idle(stretch, 4);
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(3, 1)) send_tick(stretch);
		end
	endtask

	// Receiver: random back-pressure, plus the long hold-off on request.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				repeat (sink_hold) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
				sink_hold = 0;
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_TICK;
		cfg_we = 1'b0;
		cfg_index = REG_HALF_DELAY;
		cfg_data = '0;
		sink_hold = 0;
		items_sent = 0;
		src_idle_pct = 8;
		sink_idle_pct = 63;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset delays. Ticks on an idle engine change
		// nothing; a stop offered during a start is dropped; writes with all
		// ones and all zeros; reads with ACK and with NACK; a stretched write.
		send_tick(0);
		send_tick(100);
		issue(CMD_START, 8'h00, 1'b0);
		issue(CMD_STOP, 8'hFF, 1'b1);
		tick_until_idle(0, 0);
		issue(CMD_WRITE, 8'hFF, 1'b0);
		tick_until_idle(30, 0);
		issue(CMD_WRITE, 8'h00, 1'b1);
		tick_until_idle(0, 0);
		issue(CMD_READ, 8'h00, 1'b1);
		tick_until_idle(10, 0);
		issue(CMD_READ, 8'hFF, 1'b0);
		tick_until_idle(0, 0);
		issue(CMD_STOP, 8'h00, 1'b0);
		tick_until_idle(0, 0);

		// Short delays keep each byte to a few dozen ticks. The zero settings
		// must behave as one tick.
		settle();
		write_delays(16'd2, 16'd1);
		random_phase(200, 1'b1, 1'b0);

		settle();
		src_idle_pct = 63;
		sink_idle_pct = 8;
		write_delays(16'd0, 16'd1);
		random_phase(200, 1'b0, 1'b1);

		settle();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		write_delays(16'd1, 16'd0);
		random_phase(150, 1'b0, 1'b0);

		// A long half delay on a start, then a long quarter delay on a stop.
		settle();
		write_delays(16'd60, 16'd1);
		issue(CMD_START, 8'h00, 1'b0);
		tick_until_idle(0, 0);
		settle();
		write_delays(16'd1, 16'd60);
		issue(CMD_STOP, 8'h00, 1'b0);
		tick_until_idle(0, 0);

		settle();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("** i2c_master_byte_engine: PASSED **");
		else
			$display("** i2c_master_byte_engine: FAILED **");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("** i2c_master_byte_engine: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/i2cm_pkg.sv
src/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_checker.sv
tb/tb_i2c_master_byte_engine.sv
